// ----- rtl/core/pssm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_pkg : shared definitions for the PWM soft-start motor controller
// Field widths, command and register codes, and the request/response
// structs of the serial multiply-divide unit.
// ----------------------------------------------------------------------------
package pssm_pkg;

  localparam int OP_W       = 3;
  localparam int VAL_W      = 8;
  localparam int TIME_W     = 32;
  localparam int PCT_W      = 7;
  localparam int PER_W      = 16;
  localparam int CMPV_W     = 17;
  localparam int MS_W       = 16;
  localparam int IDX_W      = 2;
  localparam int CFG_DATA_W = 16;
  // duty (<= 100) times period ticks (<= 65536) fits in 23 bits
  localparam int PROD_W     = 23;
  localparam int CNT_W      = $clog2(PROD_W);

  // command codes
  localparam logic [OP_W-1:0] OP_SET_DUTY = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_DIR  = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_STOP = 3'd2;
  localparam logic [OP_W-1:0] OP_START    = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP     = 3'd4;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd5;

  // register indexes
  localparam logic [IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [IDX_W-1:0] REG_SS_MS  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SS_EN  = 2'd2;

  localparam logic [PER_W-1:0] PERIOD_RST = 16'd999;
  localparam logic [MS_W-1:0]  SS_MS_RST  = 16'd2000;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef struct packed {
    logic              start;
    logic [PCT_W-1:0]  mplier;
    logic [CMPV_W-1:0] mcand;
    logic [MS_W-1:0]   divisor;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
  } md_rsp_t;

  function automatic logic [PCT_W-1:0] clamp_pct(input logic [VAL_W-1:0] v);
    logic [PCT_W-1:0] r;
    if (v > {1'b0, PCT_FULL}) begin
      r = PCT_FULL;
    end else begin
      r = v[PCT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pssm_cmd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_cmd_if : command channel
// Valid/ready channel carrying one motor command word.
// ----------------------------------------------------------------------------
interface pssm_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [pssm_pkg::OP_W-1:0]   op;
  logic [pssm_pkg::VAL_W-1:0]  value;
  logic [pssm_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output op, output value, output now_ms, input ready);
  modport sink   (input valid, input op, input value, input now_ms, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pssm_res_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_res_if : result channel
// Valid/ready channel carrying the drive state after each command.
// ----------------------------------------------------------------------------
interface pssm_res_if;
  logic                        valid;
  logic                        ready;
  logic [pssm_pkg::CMPV_W-1:0] compare_value;
  logic                        stop_pin;
  logic                        dir_pin;
  logic [pssm_pkg::PCT_W-1:0]  duty_percent;
  logic                        ramping;
  logic [pssm_pkg::MS_W-1:0]   ramp_elapsed;

  modport source (output valid, output compare_value, output stop_pin, output dir_pin,
                  output duty_percent, output ramping, output ramp_elapsed, input ready);
  modport sink   (input valid, input compare_value, input stop_pin, input dir_pin,
                  input duty_percent, input ramping, input ramp_elapsed, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pssm_cfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_cfg_if : configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface pssm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pssm_pkg::IDX_W-1:0]      index;
  logic [pssm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pwm_soft_start_motor_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_soft_start_motor_ctrl : motor drive command block with soft start
// Takes one command word at a time (duty, direction, stop, start, stop,
// millisecond tick) and returns the drive state after it: compare value,
// stop and direction pins, duty, ramp flag and ramp elapsed time.
//
//   channel  | role   | payload                                   | handshake
//   ---------+--------+-------------------------------------------+-----------
//   in_cmd   | sink   | op, value, now_ms                         | valid/ready
//   out_res  | source | compare_value, stop_pin, dir_pin,         | valid/ready
//            |        | duty_percent, ramping, ramp_elapsed       |
//   cfg_wr   | sink   | index, data                               | valid/ready
//
// Work: a command that needs no arithmetic makes no pass of the shared
//   serial unit; one pass when the compare value is recomputed, or for a
//   ramp tick whose duty does not move; two for a ramp tick that moves the
//   duty (one pass for the ramp quotient, one for the compare value). Each
//   pass is 7 multiply steps and 23 divide steps of the shared serial unit.
// Reset: rst_n synchronous, active low; stop asserted, direction reverse.
// Stalls: in_cmd.ready is high only when no command is in progress; a
//   finished result waits in the output register while out_res.ready is low.
// cfg_wr is always ready; a write to an unknown index is dropped.
// ----------------------------------------------------------------------------
module pwm_soft_start_motor_ctrl (
  input  logic       clk,
  input  logic       rst_n,
  pssm_cmd_if.sink   in_cmd,
  pssm_res_if.source out_res,
  pssm_cfg_if.sink   cfg_wr
);
  import pssm_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_DIV_GO   = 3'd2;
  localparam logic [2:0] S_DIV_WAIT = 3'd3;
  localparam logic [2:0] S_CMP_GO   = 3'd4;
  localparam logic [2:0] S_CMP_WAIT = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  logic [2:0] state_r, state_nxt;

  // configuration
  logic [PER_W-1:0] period_r;
  logic [MS_W-1:0]  ms_r;
  logic             ss_en_r;

  // latched command word
  logic [OP_W-1:0]   op_r;
  logic [VAL_W-1:0]  val_r;
  logic [TIME_W-1:0] now_r;

  // drive state
  logic [PCT_W-1:0]  duty_r, duty_nxt;
  logic [PCT_W-1:0]  target_r, target_nxt;
  logic              ramp_r, ramp_nxt;
  logic              stopped_r, stopped_nxt;
  logic              reverse_r, reverse_nxt;
  logic [TIME_W-1:0] start_time_r, start_time_nxt;
  logic [MS_W-1:0]   elapsed_r, elapsed_nxt;
  logic [CMPV_W-1:0] compare_r, compare_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [CMPV_W-1:0] o_cmp_r;
  logic              o_stop_r, o_dir_r, o_ramp_r;
  logic [PCT_W-1:0]  o_duty_r;
  logic [MS_W-1:0]   o_el_r;

  logic [PCT_W-1:0]  pct;
  logic [TIME_W-1:0] el;
  logic              el_done;
  logic [CMPV_W-1:0] ticks;
  logic [PCT_W-1:0]  ramp_duty;
  logic              cmd_acc;

  md_req_t md_req;
  md_rsp_t md_rsp;

  assign in_cmd.ready = (state_r == S_IDLE);
  assign cmd_acc      = in_cmd.valid && in_cmd.ready;
  assign cfg_wr.ready = 1'b1;

  assign pct       = clamp_pct(val_r);
  assign el        = now_r - start_time_r;      // wraps like the timer
  assign el_done   = (el >= {{(TIME_W-MS_W){1'b0}}, ms_r});
  assign ticks     = {1'b0, period_r} + 17'd1;
  assign ramp_duty = md_rsp.quot[PCT_W-1:0];    // below target, so fits

  // shared unit: ramp step target*el/ms, or compare duty*ticks/100
  always_comb begin
    md_req.start = (state_r == S_DIV_GO) || (state_r == S_CMP_GO);
    if (state_r == S_DIV_GO) begin
      md_req.mplier  = target_r;
      md_req.mcand   = {1'b0, elapsed_r};
      md_req.divisor = ms_r;
    end else begin
      md_req.mplier  = duty_r;
      md_req.mcand   = ticks;
      md_req.divisor = {{(MS_W-PCT_W){1'b0}}, PCT_FULL};
    end
  end

  pssm_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  // command sequencer
  always_comb begin
    state_nxt      = state_r;
    duty_nxt       = duty_r;
    target_nxt     = target_r;
    ramp_nxt       = ramp_r;
    stopped_nxt    = stopped_r;
    reverse_nxt    = reverse_r;
    start_time_nxt = start_time_r;
    elapsed_nxt    = elapsed_r;
    compare_nxt    = compare_r;
    out_load       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        unique case (op_r)
          OP_SET_DUTY: begin
            ramp_nxt    = 1'b0;
            target_nxt  = pct;
            elapsed_nxt = '0;
            duty_nxt    = pct;
            // while stopped the compare value stays at zero
            if (!stopped_r) begin
              state_nxt = S_CMP_GO;
            end
          end
          OP_SET_DIR: begin
            reverse_nxt = (val_r != '0);
          end
          OP_SET_STOP: begin
            if (val_r != '0) begin
              compare_nxt = '0;
              duty_nxt    = '0;
              stopped_nxt = 1'b1;
              ramp_nxt    = 1'b0;
              elapsed_nxt = '0;
            end else begin
              stopped_nxt = 1'b0;
              state_nxt   = S_CMP_GO;
            end
          end
          OP_START: begin
            compare_nxt = '0;
            stopped_nxt = 1'b1;
            target_nxt  = pct;
            elapsed_nxt = '0;
            if (ss_en_r) begin
              duty_nxt       = '0;
              start_time_nxt = now_r;
              ramp_nxt       = (pct != '0);
            end else begin
              duty_nxt = pct;
              ramp_nxt = 1'b0;
            end
            // zero percent leaves the drive stopped
            if (pct != '0) begin
              stopped_nxt = 1'b0;
              state_nxt   = S_CMP_GO;
            end
          end
          OP_STOP: begin
            compare_nxt = '0;
            duty_nxt    = '0;
            stopped_nxt = 1'b1;
            ramp_nxt    = 1'b0;
            elapsed_nxt = '0;
          end
          OP_TICK: begin
            if (ramp_r && !stopped_r) begin
              if (el_done) begin
                // ramp complete (also covers a zero ramp time)
                elapsed_nxt = ms_r;
                duty_nxt    = target_r;
                ramp_nxt    = 1'b0;
                state_nxt   = S_CMP_GO;
              end else begin
                elapsed_nxt = el[MS_W-1:0];
                state_nxt   = S_DIV_GO;
              end
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_DIV_GO: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (md_rsp.done) begin
          if (ramp_duty != duty_r) begin
            duty_nxt  = ramp_duty;
            state_nxt = S_CMP_GO;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_CMP_GO: begin
        state_nxt = S_CMP_WAIT;
      end
      S_CMP_WAIT: begin
        if (md_rsp.done) begin
          compare_nxt = md_rsp.quot[CMPV_W-1:0];
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_res.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_res.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      duty_r       <= '0;
      target_r     <= '0;
      ramp_r       <= 1'b0;
      stopped_r    <= 1'b1;
      reverse_r    <= 1'b1;
      start_time_r <= '0;
      elapsed_r    <= '0;
      compare_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      duty_r       <= duty_nxt;
      target_r     <= target_nxt;
      ramp_r       <= ramp_nxt;
      stopped_r    <= stopped_nxt;
      reverse_r    <= reverse_nxt;
      start_time_r <= start_time_nxt;
      elapsed_r    <= elapsed_nxt;
      compare_r    <= compare_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      ms_r     <= SS_MS_RST;
      ss_en_r  <= 1'b1;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_wr.index)
        REG_PERIOD: period_r <= cfg_wr.data[PER_W-1:0];
        REG_SS_MS:  ms_r     <= cfg_wr.data[MS_W-1:0];
        REG_SS_EN:  ss_en_r  <= cfg_wr.data[0];
        default: begin
          period_r <= period_r;
        end
      endcase
    end
  end

  // command word and result payload
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      op_r  <= in_cmd.op;
      val_r <= in_cmd.value;
      now_r <= in_cmd.now_ms;
    end
    if (out_load) begin
      o_cmp_r  <= compare_r;
      o_stop_r <= !stopped_r;
      o_dir_r  <= !reverse_r;
      o_duty_r <= duty_r;
      o_ramp_r <= ramp_r;
      o_el_r   <= elapsed_r;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.compare_value = o_cmp_r;
  assign out_res.stop_pin      = o_stop_r;
  assign out_res.dir_pin       = o_dir_r;
  assign out_res.duty_percent  = o_duty_r;
  assign out_res.ramping       = o_ramp_r;
  assign out_res.ramp_elapsed  = o_el_r;

  // a ramp never runs with the drive stopped
  a_ramp_not_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_r |-> !stopped_r)
    else $error("ramp active while stopped");

  // stop holds the compare value at zero
  a_stop_zero_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (compare_r == '0))
    else $error("compare value nonzero while stopped");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (duty_r <= PCT_FULL) && (target_r <= PCT_FULL))
    else $error("duty or target above full scale");

  // the unit only answers while the sequencer waits for it
  a_md_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> ((state_r == S_DIV_WAIT) || (state_r == S_CMP_WAIT)))
    else $error("unexpected muldiv completion");

  // a result is loaded only once the previous word has left
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |=> (state_r != S_IDLE) || out_valid_r)
    else $error("pending result lost");

endmodule
`default_nettype wire

// ----- rtl/core/pssm_muldiv.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_muldiv : serial multiply then divide
// Computes (mplier * mcand) / divisor, truncated. Shift-add multiply, one
// bit per cycle, then restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pssm_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  pssm_pkg::md_req_t req,
  output pssm_pkg::md_rsp_t rsp
);
  import pssm_pkg::*;

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;

  logic [1:0]        phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [PCT_W-1:0]  mplier_r, mplier_nxt;
  logic [PROD_W-1:0] mcand_r, mcand_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;     // product, then numerator/quotient
  logic [MS_W-1:0]   div_r, div_nxt;
  logic [MS_W-1:0]   rem_r, rem_nxt;
  logic [MS_W:0]     rem_sh, rem_diff;
  logic              q_bit;

  assign rem_sh   = {rem_r, acc_r[PROD_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign q_bit    = (rem_sh >= {1'b0, div_r});

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    mplier_nxt = mplier_r;
    mcand_nxt  = mcand_r;
    acc_nxt    = acc_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    unique case (phase_r)
      U_IDLE: begin
        if (req.start) begin
          mplier_nxt = req.mplier;
          mcand_nxt  = {{(PROD_W-CMPV_W){1'b0}}, req.mcand};
          acc_nxt    = '0;
          div_nxt    = req.divisor;
          rem_nxt    = '0;
          cnt_nxt    = CNT_W'(PCT_W-1);
          phase_nxt  = U_MUL;
        end
      end
      U_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mplier_nxt = mplier_r >> 1;
        mcand_nxt  = mcand_r << 1;
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(PROD_W-1);
          phase_nxt = U_DIV;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      U_DIV: begin
        rem_nxt = q_bit ? rem_diff[MS_W-1:0] : rem_sh[MS_W-1:0];
        acc_nxt = {acc_r[PROD_W-2:0], q_bit};
        if (cnt_r == '0) begin
          phase_nxt = U_IDLE;
          done_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        phase_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= U_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mplier_r <= mplier_nxt;
    mcand_r  <= mcand_nxt;
    acc_r    <= acc_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = acc_r;

endmodule
`default_nettype wire
